@@ hw/rtl/ktnd_pkg.sv @@
// Shared constants, types and state codes for the k-ary tree node distance block.
package ktnd_pkg;

    localparam int NODE_BITS  = 48;
    localparam int ARITY_BITS = 32;
    localparam int UNIT_W     = (NODE_BITS > ARITY_BITS) ? NODE_BITS : ARITY_BITS;
    localparam int STEP_W     = $clog2(UNIT_W + 1);
    localparam int LVL_W      = $clog2(NODE_BITS + 2);

    localparam logic [NODE_BITS-1:0]  NODE_MASK   = {NODE_BITS{1'b1}};
    localparam logic [NODE_BITS-1:0]  NODE_ONE    = NODE_BITS'(1);
    localparam logic [NODE_BITS-1:0]  NODE_TWO    = NODE_BITS'(2);
    localparam logic [ARITY_BITS-1:0] ARITY_RESET = ARITY_BITS'(2);
    localparam logic [ARITY_BITS-1:0] ARITY_CHAIN = ARITY_BITS'(1);

    typedef enum logic {
        OP_DIV,
        OP_MUL
    } t_unit_op;

    typedef struct packed {
        logic                  start;
        t_unit_op              op;
        logic [NODE_BITS-1:0]  a;
        logic [ARITY_BITS-1:0] b;
    } t_unit_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [NODE_BITS-1:0] result;
    } t_unit_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEPTH,
        S_DEPTH_W,
        S_LIMIT_W,
        S_COUNT,
        S_COUNT_W,
        S_CLIMB,
        S_CLIMB_W,
        S_PAIR,
        S_PAIR_HI_W,
        S_PAIR_LO,
        S_PAIR_LO_W,
        S_DONE
    } t_state;

endpackage

@@ hw/rtl/ktnd_shared_unit.sv @@
// Shared bit-serial unit: restoring divide (a / b) or shift-add multiply (a * b).
module ktnd_shared_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ktnd_pkg::t_unit_req i_req,
    output ktnd_pkg::t_unit_rsp o_rsp
);
    import ktnd_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    t_unit_op          r_op;
    logic [UNIT_W-1:0] r_q;
    logic [UNIT_W-1:0] r_acc;
    logic [UNIT_W-1:0] r_opnd;

    logic              is_div;
    logic [UNIT_W:0]   shifted;
    logic [UNIT_W:0]   addend;
    logic [UNIT_W+1:0] sum;
    logic              no_borrow;

    assign is_div    = (r_op == OP_DIV);
    assign shifted   = {r_acc, is_div ? r_q[UNIT_W-1] : 1'b0};
    assign addend    = is_div ? ~{1'b0, r_opnd} :
                       (r_q[UNIT_W-1] ? {1'b0, r_opnd} : '0);
    assign sum       = {1'b0, shifted} + {1'b0, addend} + (UNIT_W+2)'(is_div);
    assign no_borrow = sum[UNIT_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_req.op == OP_DIV) ? STEP_W'(UNIT_W) : STEP_W'(ARITY_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_op  <= i_req.op;
            r_acc <= '0;
            if (i_req.op == OP_DIV) begin
                r_q    <= UNIT_W'(i_req.a);
                r_opnd <= UNIT_W'(i_req.b);
            end else begin
                r_q    <= UNIT_W'(i_req.b) << (UNIT_W - ARITY_BITS);
                r_opnd <= UNIT_W'(i_req.a);
            end
        end else if (r_busy) begin
            if (is_div) begin
                r_acc <= no_borrow ? sum[UNIT_W-1:0] : shifted[UNIT_W-1:0];
                r_q   <= {r_q[UNIT_W-2:0], no_borrow};
            end else begin
                r_acc <= sum[UNIT_W-1:0];
                r_q   <= {r_q[UNIT_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = is_div ? r_q[NODE_BITS-1:0] : r_acc[NODE_BITS-1:0];

endmodule

@@ hw/rtl/kary_tree_node_distance.sv @@
// Edge distance between two breadth-first node indices of a complete k-ary tree.
// One transfer at a time: after an input transfer the input stalls until the result is
// in the output register. Arity 0 or 1 gives the index difference without the divider. Otherwise
// every parent step is one pass through the shared serial divider, and each level of
// the node count takes at most one serial multiply. The result register lets the next
// input transfer start while a result waits.
module kary_tree_node_distance (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [ktnd_pkg::ARITY_BITS-1:0]     i_cfg_wr_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [ktnd_pkg::NODE_BITS-1:0]      i_first_node,
    input  logic [ktnd_pkg::NODE_BITS-1:0]      i_second_node,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [ktnd_pkg::NODE_BITS-1:0]      o_distance
);
    import ktnd_pkg::*;

    t_state                r_state, n_state;
    logic [ARITY_BITS-1:0] r_arity;
    logic                  r_ovalid, n_ovalid;
    logic [NODE_BITS-1:0]  r_dist, n_dist;
    logic [NODE_BITS-1:0]  r_lo, n_lo;
    logic [NODE_BITS-1:0]  r_hi, n_hi;
    logic [NODE_BITS-1:0]  r_node, n_node;
    logic [NODE_BITS-1:0]  r_count, n_count;
    logic [NODE_BITS-1:0]  r_width, n_width;
    logic [NODE_BITS-1:0]  r_limit, n_limit;
    logic [NODE_BITS-1:0]  r_steps, n_steps;
    logic [LVL_W-1:0]      r_levels, n_levels;

    t_unit_req             req;
    t_unit_rsp             rsp;

    logic [NODE_BITS-1:0]  node_a, node_b, in_lo, in_hi;
    logic [NODE_BITS:0]    count_sum;
    logic [NODE_BITS-1:0]  lifted;

    ktnd_shared_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    assign node_a    = (i_first_node == '0) ? NODE_ONE : i_first_node;
    assign node_b    = (i_second_node == '0) ? NODE_ONE : i_second_node;
    assign in_lo     = (node_a < node_b) ? node_a : node_b;
    assign in_hi     = (node_a < node_b) ? node_b : node_a;
    assign count_sum = {1'b0, r_count} + {1'b0, r_width};
    assign lifted    = rsp.result + NODE_ONE;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        n_dist   = r_dist;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_node   = r_node;
        n_count  = r_count;
        n_width  = r_width;
        n_limit  = r_limit;
        n_steps  = r_steps;
        n_levels = r_levels;
        req      = '{start: 1'b0, op: OP_DIV, a: '0, b: r_arity};

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_lo = in_lo;
                    n_hi = in_hi;
                    if (r_arity <= ARITY_CHAIN) begin
                        n_steps = in_hi - in_lo;
                        n_state = S_DONE;
                    end else begin
                        n_node   = in_lo;
                        n_levels = LVL_W'(1);
                        n_steps  = '0;
                        n_count  = '0;
                        n_width  = NODE_ONE;
                        n_state  = S_DEPTH;
                    end
                end
            end
            S_DEPTH: begin
                req.start = 1'b1;
                if (r_node == NODE_ONE) begin
                    req.a   = NODE_MASK;
                    n_state = S_LIMIT_W;
                end else begin
                    req.a   = r_node - NODE_TWO;
                    n_state = S_DEPTH_W;
                end
            end
            S_DEPTH_W: begin
                if (rsp.done) begin
                    n_node   = lifted;
                    n_levels = r_levels + LVL_W'(1);
                    n_state  = S_DEPTH;
                end
            end
            S_LIMIT_W: begin
                if (rsp.done) begin
                    n_limit = rsp.result;
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                if (count_sum[NODE_BITS]) begin
                    n_count = NODE_MASK;
                    n_state = S_CLIMB;
                end else begin
                    n_count  = count_sum[NODE_BITS-1:0];
                    n_levels = r_levels - LVL_W'(1);
                    if (r_levels == LVL_W'(1)) begin
                        n_state = S_CLIMB;
                    end else if (r_width > r_limit) begin
                        n_width = NODE_MASK;
                    end else begin
                        req.start = 1'b1;
                        req.op    = OP_MUL;
                        req.a     = r_width;
                        n_state   = S_COUNT_W;
                    end
                end
            end
            S_COUNT_W: begin
                if (rsp.done) begin
                    n_width = rsp.result;
                    n_state = S_COUNT;
                end
            end
            S_CLIMB: begin
                if (r_count >= r_hi) begin
                    n_state = S_PAIR;
                end else if (r_hi < NODE_TWO) begin
                    n_hi    = NODE_ONE;
                    n_steps = r_steps + NODE_ONE;
                end else begin
                    req.start = 1'b1;
                    req.a     = r_hi - NODE_TWO;
                    n_state   = S_CLIMB_W;
                end
            end
            S_CLIMB_W: begin
                if (rsp.done) begin
                    n_hi    = lifted;
                    n_steps = r_steps + NODE_ONE;
                    n_state = S_CLIMB;
                end
            end
            S_PAIR: begin
                if (r_hi == r_lo) begin
                    n_state = S_DONE;
                end else if (r_hi < NODE_TWO) begin
                    n_hi    = NODE_ONE;
                    n_state = S_PAIR_LO;
                end else begin
                    req.start = 1'b1;
                    req.a     = r_hi - NODE_TWO;
                    n_state   = S_PAIR_HI_W;
                end
            end
            S_PAIR_HI_W: begin
                if (rsp.done) begin
                    n_hi    = lifted;
                    n_state = S_PAIR_LO;
                end
            end
            S_PAIR_LO: begin
                if (r_lo < NODE_TWO) begin
                    n_lo    = NODE_ONE;
                    n_steps = r_steps + NODE_TWO;
                    n_state = S_PAIR;
                end else begin
                    req.start = 1'b1;
                    req.a     = r_lo - NODE_TWO;
                    n_state   = S_PAIR_LO_W;
                end
            end
            S_PAIR_LO_W: begin
                if (rsp.done) begin
                    n_lo    = lifted;
                    n_steps = r_steps + NODE_TWO;
                    n_state = S_PAIR;
                end
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_dist   = r_steps;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_arity  <= ARITY_RESET;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_wr_en) begin
                r_arity <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist   <= n_dist;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_node   <= n_node;
        r_count  <= n_count;
        r_width  <= n_width;
        r_limit  <= n_limit;
        r_steps  <= n_steps;
        r_levels <= n_levels;
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_ovalid;
    assign o_distance = r_dist;

    // unit is only started when free
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.start |-> !rsp.busy)
        else $error("shared unit started while busy");

    // unit completion only lands in a wait state
    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.done |-> (r_state == S_DEPTH_W || r_state == S_LIMIT_W ||
                      r_state == S_COUNT_W || r_state == S_CLIMB_W ||
                      r_state == S_PAIR_HI_W || r_state == S_PAIR_LO_W))
        else $error("shared unit result arrived outside a wait state");

    // an input transfer closes the input until its result is out
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input open right after a transfer");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("output valid or input stalled after reset");

endmodule
